@@ hdl/atks_pkg.sv @@
// Package for the accelerometer tilt Kalman smoother core.
// Holds shared widths, constants, the CORDIC arctangent table and command types.
package atks_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned TabLen      = 24;
  localparam int unsigned NumIter     = (CordicSteps < TabLen) ? CordicSteps : TabLen;
  localparam int unsigned IterW       = 5;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] REG_PROCESS_NOISE     = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_MEASUREMENT_NOISE = 1'b1;

  localparam logic [15:0] QReset = 16'd655;
  localparam logic [23:0] RReset = 24'd65536;

  localparam logic [17:0] CovOne = 18'd65536;
  localparam logic [17:0] CovMax = 18'd262143;

  localparam logic signed [15:0] AngleLimit = 16'sd23040;

  // CORDIC vector width: |x| up to ~ 2^24 * 1.65 gain plus pre-rotation
  localparam int unsigned CW = 28;
  // angle accumulator, 2^-15 degree units
  localparam int unsigned ZW = 24;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } accel_req_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_smoothed;
    logic signed [15:0] pitch_smoothed;
  } tilt_rsp_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SQRT_STEP,
    CMD_ROLL_INIT,
    CMD_PITCH_INIT,
    CMD_CORDIC_STEP,
    CMD_ROLL_DONE,
    CMD_PITCH_DONE,
    CMD_KAL_SEL_ROLL,
    CMD_KAL_SEL_PITCH,
    CMD_KAL_PREP,
    CMD_KAL_DIV_STEP,
    CMD_KAL_MUL,
    CMD_KAL_UPDATE,
    CMD_PRIME
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [4:0] step;
  } dp_ctrl_t;

  function automatic logic [ZW-1:0] atan_tab(input logic [IterW-1:0] i);
    logic [ZW-1:0] v;
    case (i)
      5'd0:  v = 24'd1474560;
      5'd1:  v = 24'd870484;
      5'd2:  v = 24'd459940;
      5'd3:  v = 24'd233473;
      5'd4:  v = 24'd117189;
      5'd5:  v = 24'd58653;
      5'd6:  v = 24'd29333;
      5'd7:  v = 24'd14667;
      5'd8:  v = 24'd7334;
      5'd9:  v = 24'd3667;
      5'd10: v = 24'd1833;
      5'd11: v = 24'd917;
      5'd12: v = 24'd458;
      5'd13: v = 24'd229;
      5'd14: v = 24'd115;
      5'd15: v = 24'd57;
      5'd16: v = 24'd29;
      5'd17: v = 24'd14;
      5'd18: v = 24'd7;
      5'd19: v = 24'd4;
      5'd20: v = 24'd2;
      5'd21: v = 24'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/atks_stream_if.sv @@
// Valid/ready stream interface used for sample requests and results.
// The payload type is given by a parameter; the interface does not import atks_pkg.
interface atks_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/atks_ctrl.sv @@
// Sequencer for the tilt smoother: steps root, two CORDIC runs and, once primed, two Kalman updates.
// Depends on atks_pkg; drives commands into atks_datapath.
module atks_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  input  logic                primed_i,
  output atks_pkg::dp_ctrl_t  ctrl_o
);
  import atks_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SQRT, S_RINIT, S_RCORD, S_RDONE, S_PINIT, S_PCORD, S_PDONE,
    S_KSEL, S_KPREP, S_KDIV, S_KMUL, S_KUPD, S_OUT
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       pitch_q, pitch_d;
  logic       rsp_valid_q, rsp_valid_d;

  assign req_ready_o = (state_q == S_IDLE) && !rsp_valid_q;
  assign rsp_valid_o = rsp_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pitch_d     = pitch_q;
    rsp_valid_d = rsp_valid_q;
    ctrl_o.cmd  = CMD_NONE;
    ctrl_o.step = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i && !rsp_valid_q) begin
          ctrl_o.cmd = CMD_LOAD;
          cnt_d      = '0;
          state_d    = S_SQRT;
        end
      end
      S_SQRT: begin
        ctrl_o.cmd = CMD_SQRT_STEP;
        cnt_d      = cnt_q + 5'd1;
        if (cnt_q == 5'd24) state_d = S_RINIT;
      end
      S_RINIT: begin
        ctrl_o.cmd = CMD_ROLL_INIT;
        cnt_d      = '0;
        state_d    = S_RCORD;
      end
      S_RCORD: begin
        ctrl_o.cmd = CMD_CORDIC_STEP;
        cnt_d      = cnt_q + 5'd1;
        if (cnt_q == 5'(NumIter - 1)) state_d = S_RDONE;
      end
      S_RDONE: begin
        ctrl_o.cmd = CMD_ROLL_DONE;
        state_d    = S_PINIT;
      end
      S_PINIT: begin
        ctrl_o.cmd = CMD_PITCH_INIT;
        cnt_d      = '0;
        state_d    = S_PCORD;
      end
      S_PCORD: begin
        ctrl_o.cmd = CMD_CORDIC_STEP;
        cnt_d      = cnt_q + 5'd1;
        if (cnt_q == 5'(NumIter - 1)) state_d = S_PDONE;
      end
      S_PDONE: begin
        ctrl_o.cmd = CMD_PITCH_DONE;
        pitch_d    = 1'b0;
        state_d    = primed_i ? S_KSEL : S_OUT;
        if (!primed_i) ctrl_o.cmd = CMD_PITCH_DONE;
      end
      S_KSEL: begin
        ctrl_o.cmd = pitch_q ? CMD_KAL_SEL_PITCH : CMD_KAL_SEL_ROLL;
        state_d    = S_KPREP;
      end
      S_KPREP: begin
        ctrl_o.cmd = CMD_KAL_PREP;
        cnt_d      = '0;
        state_d    = S_KDIV;
      end
      S_KDIV: begin
        ctrl_o.cmd = CMD_KAL_DIV_STEP;
        cnt_d      = cnt_q + 5'd1;
        if (cnt_q == 5'd17) state_d = S_KMUL;
      end
      S_KMUL: begin
        ctrl_o.cmd = CMD_KAL_MUL;
        state_d    = S_KUPD;
      end
      S_KUPD: begin
        ctrl_o.cmd = CMD_KAL_UPDATE;
        pitch_d    = 1'b1;
        state_d    = pitch_q ? S_OUT : S_KSEL;
      end
      S_OUT: begin
        if (!rsp_valid_q) begin
          ctrl_o.cmd  = primed_i ? CMD_NONE : CMD_PRIME;
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else if (rsp_ready_i) begin
          rsp_valid_d = 1'b0;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (state_q != S_OUT && rsp_valid_q && rsp_ready_i) rsp_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pitch_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pitch_q     <= pitch_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end
endmodule

@@ hdl/atks_datapath.sv @@
// Datapath: bit-serial square root, shared vectoring CORDIC, Kalman divider and update.
// Depends on atks_pkg; commanded by atks_ctrl.
module atks_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  atks_pkg::dp_ctrl_t      ctrl_i,
  input  atks_pkg::accel_req_t    req_i,
  input  logic                    cfg_we_i,
  input  logic [atks_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [atks_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                    primed_o,
  output atks_pkg::tilt_rsp_t     rsp_o
);
  import atks_pkg::*;

  logic [15:0] q_q;
  logic [23:0] r_q;
  logic signed [15:0] ax_q, ay_q, az_q;

  // square root of (ay^2+az^2)<<16, 48-bit radicand, 24-bit root
  logic [47:0] rad_q;
  logic [25:0] rem_q;
  logic [23:0] root_q;
  logic [25:0] rem_t, trial;
  logic [31:0] sqy, sqz;

  logic signed [CW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic                 zero_q;

  logic signed [15:0] roll_q, pitch_q;
  logic signed [15:0] rest_q, pest_q;
  logic [17:0]        rcov_q, pcov_q;
  logic               primed_q;

  logic [17:0] p1_q;
  logic [24:0] den_q;
  logic [16:0] k_q;
  logic signed [15:0] est_sel, meas_sel;
  logic [17:0]        cov_sel;
  logic signed [34:0] kd_q;
  logic [34:0]        pn_q;

  assign primed_o = primed_q;
  assign sqy = 32'($signed(ay_q) * $signed(ay_q));
  assign sqz = 32'($signed(az_q) * $signed(az_q));

  assign trial = {rem_q[23:0], rad_q[47:46]};
  assign rem_t = trial - {root_q, 2'b01};

  function automatic logic signed [15:0] finish(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] r;
    r = (z + ZW'(128)) >>> 8;
    if (r > ZW'(AngleLimit)) return AngleLimit;
    if (r < -ZW'(AngleLimit)) return -AngleLimit;
    return r[15:0];
  endfunction

  always_comb begin
    est_sel  = ctrl_i.cmd == CMD_KAL_SEL_PITCH ? pest_q : rest_q;
    meas_sel = ctrl_i.cmd == CMD_KAL_SEL_PITCH ? pitch_q : roll_q;
    cov_sel  = ctrl_i.cmd == CMD_KAL_SEL_PITCH ? pcov_q : rcov_q;
  end

  logic signed [15:0] est_q, meas_q;
  logic [17:0]        cov_q;
  logic               sel_p_q;
  logic [18:0]        p1s;
  logic [17:0]        p1_sat;
  logic signed [16:0] diff;
  logic signed [15:0] est_n;
  logic [17:0]        cov_n;
  logic signed [CW-1:0] dx, dy;
  logic signed [CW-1:0] ix, iy;
  logic signed [ZW-1:0] iz;

  always_comb begin
    p1s  = {1'b0, cov_q} + {3'b0, q_q};
    p1_sat = p1s > 19'(CovMax) ? CovMax : p1s[17:0];
    diff = 17'(meas_q) - 17'(est_q);
    est_n = 16'(est_q + 16'((kd_q + 35'sd32768) >>> 16));
    cov_n = ((pn_q + 35'd32768) >> 16) > 35'(CovMax) ? CovMax : 18'((pn_q + 35'd32768) >> 16);
    dx = x_q >>> ctrl_i.step;
    dy = y_q >>> ctrl_i.step;
  end

  // pre-rotation for a CORDIC start vector (y over x)
  task automatic prerot(input logic signed [CW-1:0] y, input logic signed [CW-1:0] x,
                        output logic signed [CW-1:0] xo, output logic signed [CW-1:0] yo,
                        output logic signed [ZW-1:0] zo);
    begin
      xo = x; yo = y; zo = '0;
      if (x < 0) begin
        if (y >= 0) begin xo = y; yo = -x; zo = ZW'(90 * 32768); end
        else begin xo = -y; yo = x; zo = -ZW'(90 * 32768); end
      end
    end
  endtask

  always_comb begin
    ix = '0; iy = '0; iz = '0;
    if (ctrl_i.cmd == CMD_ROLL_INIT)
      prerot(CW'(ay_q) <<< 8, CW'(az_q) <<< 8, ix, iy, iz);
    else
      prerot(-(CW'(ax_q) <<< 8), CW'({1'b0, root_q}), ix, iy, iz);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q      <= QReset;
      r_q      <= RReset;
      rest_q   <= '0;
      pest_q   <= '0;
      rcov_q   <= CovOne;
      pcov_q   <= CovOne;
      primed_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_PROCESS_NOISE) q_q <= cfg_data_i[15:0];
        else r_q <= cfg_data_i;
      end
      if (ctrl_i.cmd == CMD_KAL_UPDATE) begin
        if (sel_p_q) begin pest_q <= est_n; pcov_q <= cov_n; end
        else begin rest_q <= est_n; rcov_q <= cov_n; end
      end
      if (ctrl_i.cmd == CMD_PRIME) begin
        rest_q   <= roll_q;
        pest_q   <= pitch_q;
        rcov_q   <= CovOne;
        pcov_q   <= CovOne;
        primed_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      CMD_LOAD: begin
        ax_q <= req_i.accel_x;
        ay_q <= req_i.accel_y;
        az_q <= req_i.accel_z;
        rem_q  <= '0;
        root_q <= '0;
      end
      CMD_SQRT_STEP: begin
        if (ctrl_i.step == 5'd0) begin
          rad_q <= (48'(sqy) + 48'(sqz)) << 16;
        end else begin
          rad_q <= rad_q << 2;
          if (!rem_t[25]) begin
            rem_q  <= rem_t;
            root_q <= {root_q[22:0], 1'b1};
          end else begin
            rem_q  <= trial;
            root_q <= {root_q[22:0], 1'b0};
          end
        end
      end
      CMD_ROLL_INIT, CMD_PITCH_INIT: begin
        x_q <= ix; y_q <= iy; z_q <= iz;
        zero_q <= (ctrl_i.cmd == CMD_ROLL_INIT) ? (ay_q == 0 && az_q == 0)
                                                 : (ax_q == 0 && root_q == 0);
      end
      CMD_CORDIC_STEP: begin
        if (y_q >= 0) begin
          x_q <= x_q + dy; y_q <= y_q - dx; z_q <= z_q + atan_tab(ctrl_i.step);
        end else begin
          x_q <= x_q - dy; y_q <= y_q + dx; z_q <= z_q - atan_tab(ctrl_i.step);
        end
      end
      CMD_ROLL_DONE:  roll_q  <= zero_q ? 16'sd0 : finish(z_q);
      CMD_PITCH_DONE: pitch_q <= zero_q ? 16'sd0 : finish(z_q);
      CMD_KAL_SEL_ROLL, CMD_KAL_SEL_PITCH: begin
        est_q   <= est_sel;
        meas_q  <= meas_sel;
        cov_q   <= cov_sel;
        sel_p_q <= (ctrl_i.cmd == CMD_KAL_SEL_PITCH);
      end
      CMD_KAL_PREP: begin
        p1_q   <= p1_sat;
        den_q  <= 25'(p1_sat) + 25'(r_q);
      end
      CMD_KAL_MUL: begin
        kd_q <= $signed({1'b0, k_q}) * diff;
        pn_q <= 35'(17'd65536 - k_q) * 35'(p1_q);
      end
      default: ;
    endcase
  end

  // gain: p1<<16 over den, one quotient bit per cycle; the quotient fits 17 bits,
  // so the remainder starts from p1>>1 and the low 17 numerator bits are shifted in
  logic [16:0] num_q;
  logic [25:0] rr_q;
  logic [16:0] quo_q;
  logic [25:0] rr_sh;
  logic [25:0] rr_dif;
  logic [25:0] rnd;
  always_comb begin
    rr_sh  = {rr_q[24:0], num_q[16]};
    rr_dif = rr_sh - {1'b0, den_q};
    rnd    = {rr_q[24:0], 1'b0};
  end
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmd == CMD_KAL_PREP) begin
      num_q <= {p1_sat[0], 16'b0};
      rr_q  <= {9'b0, p1_sat[17:1]};
      quo_q <= '0;
    end else if (ctrl_i.cmd == CMD_KAL_DIV_STEP) begin
      if (ctrl_i.step == 5'd17) begin
        // round: remainder*2 >= den
        if (den_q == 0) k_q <= '0;
        else k_q <= (rnd >= {1'b0, den_q}) ? quo_q + 17'd1 : quo_q;
      end else begin
        num_q <= num_q << 1;
        if (!rr_dif[25]) begin
          rr_q  <= rr_dif;
          quo_q <= {quo_q[15:0], 1'b1};
        end else begin
          rr_q  <= rr_sh;
          quo_q <= {quo_q[15:0], 1'b0};
        end
      end
    end
  end

  assign rsp_o.roll_angle     = roll_q;
  assign rsp_o.pitch_angle    = pitch_q;
  assign rsp_o.roll_smoothed  = primed_q ? rest_q : roll_q;
  assign rsp_o.pitch_smoothed = primed_q ? pest_q : pitch_q;
endmodule

@@ hdl/accel_tilt_kalman_smoother_core.sv @@
// Accelerometer tilt core: roll and pitch by vectoring CORDIC, each smoothed by a
// scalar Kalman filter. One request is handled at a time: a bit-serial root (load
// plus 24 steps), two CORDIC runs of 16 iterations on one shared rotator (set-up and
// finish step each), two Kalman updates, each with an 18-step gain divider, and an
// output step. The first request after reset skips the Kalman updates. A new request
// is taken only once the previous result has been accepted.
// Process and measurement noise are written through the config port; the user must
// write them only while idle, which the block itself does not enforce.
module accel_tilt_kalman_smoother_core (
  input  logic clk_i,
  input  logic rst_ni,
  atks_stream_if.sink   req,
  atks_stream_if.source rsp,
  input  logic                            cfg_we_i,
  input  logic [atks_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [atks_pkg::CfgDataW-1:0]   cfg_data_i
);
  import atks_pkg::*;

  dp_ctrl_t   ctrl;
  logic       primed;
  tilt_rsp_t  rsp_data;

  atks_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .primed_i    (primed),
    .ctrl_o      (ctrl)
  );

  atks_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .req_i      (req.data),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .primed_o   (primed),
    .rsp_o      (rsp_data)
  );

  assign rsp.data = rsp_data;
endmodule

@@ sim/accel_tilt_kalman_smoother_core_test.sv @@
// Testbench for accel_tilt_kalman_smoother_core: random and directed accelerometer
// requests, a tilt/Kalman predictor in a scoreboard class, random stalls on both sides.
// Depends on atks_pkg, atks_stream_if and the core RTL.
`timescale 1ns / 100ps

module accel_tilt_kalman_smoother_core_test;
  import atks_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  int unsigned idle_cycles = 0;
  bit stim_done = 1'b0;
  bit hold_rsp_random = 1'b1;

  atks_stream_if #(.payload_t(accel_req_t)) req_if ();
  atks_stream_if #(.payload_t(tilt_rsp_t)) rsp_if ();

  accel_tilt_kalman_smoother_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req(req_if.sink), .rsp(rsp_if.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  class tilt_scoreboard;
    logic [15:0] q_noise;
    logic [23:0] r_noise;
    longint roll_est, pitch_est;
    longint unsigned roll_cov, pitch_cov;
    bit primed;
    tilt_rsp_t tilt_q[$];
    int errors;

    function void reset_state();
      q_noise = QReset;
      r_noise = RReset;
      roll_est = 0;
      pitch_est = 0;
      roll_cov = CovOne;
      pitch_cov = CovOne;
      primed = 1'b0;
      errors = 0;
    endfunction

    function longint asr(longint v, int s);
      return v >>> s;
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function longint cordic_angle(longint y, longint x);
      longint z, t, dx, dy, r;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y; y = -t; z = 90 * 32768;
        end else begin
          x = -y; y = t; z = -90 * 32768;
        end
      end
      for (int i = 0; i < NumIter; i++) begin
        dx = asr(x, i);
        dy = asr(y, i);
        if (y >= 0) begin
          x += dy; y -= dx; z += longint'(atan_tab(i[IterW-1:0]));
        end else begin
          x -= dy; y += dx; z -= longint'(atan_tab(i[IterW-1:0]));
        end
      end
      r = asr(z + 128, 8);
      if (r > 23040) r = 23040;
      if (r < -23040) r = -23040;
      return r;
    endfunction

    function void smooth(ref longint est, ref longint unsigned cov, input longint meas);
      longint unsigned p1, den, k, pn;
      p1 = cov + q_noise;
      if (p1 > CovMax) p1 = CovMax;
      den = p1 + r_noise;
      k = (den == 0) ? 0 : ((p1 << 16) + den / 2) / den;
      if (k > 65536) k = 65536;
      est = est + asr(longint'(k) * (meas - est) + 32768, 16);
      pn = ((65536 - k) * p1 + 32768) >> 16;
      if (pn > CovMax) pn = CovMax;
      cov = pn;
    endfunction

    function void note_request(accel_req_t a);
      longint ax, ay, az, roll, pitch;
      tilt_rsp_t e;
      ax = a.accel_x;
      ay = a.accel_y;
      az = a.accel_z;
      roll = cordic_angle(ay * 256, az * 256);
      pitch = cordic_angle(-ax * 256, longint'(root(longint'((ay * ay + az * az)) << 16)));
      if (!primed) begin
        roll_est = roll; pitch_est = pitch;
        roll_cov = CovOne; pitch_cov = CovOne;
        primed = 1'b1;
      end else begin
        smooth(roll_est, roll_cov, roll);
        smooth(pitch_est, pitch_cov, pitch);
      end
      e.roll_angle = roll[15:0];
      e.pitch_angle = pitch[15:0];
      e.roll_smoothed = roll_est[15:0];
      e.pitch_smoothed = pitch_est[15:0];
      tilt_q.push_back(e);
    endfunction

    function void check_result(tilt_rsp_t got);
      tilt_rsp_t e;
      if (tilt_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = tilt_q.pop_front();
      if (got.roll_angle !== e.roll_angle)
        $display("%0t: roll_angle exp %0d got %0d", $time, e.roll_angle, got.roll_angle);
      if (got.pitch_angle !== e.pitch_angle)
        $display("%0t: pitch_angle exp %0d got %0d", $time, e.pitch_angle, got.pitch_angle);
      if (got.roll_smoothed !== e.roll_smoothed)
        $display("%0t: roll_smoothed exp %0d got %0d", $time, e.roll_smoothed,
                 got.roll_smoothed);
      if (got.pitch_smoothed !== e.pitch_smoothed)
        $display("%0t: pitch_smoothed exp %0d got %0d", $time, e.pitch_smoothed,
                 got.pitch_smoothed);
      if (got !== e) errors++;
    endfunction
  endclass

  tilt_scoreboard tilt_sb;

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 120);
  endfunction

  // sampling and checking at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) tilt_sb.note_request(req_if.data);
      if (rsp_if.valid && rsp_if.ready) tilt_sb.check_result(rsp_if.data);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  // result side stalls
  initial begin
    int unsigned g;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_rsp_random && $urandom_range(0, 3) == 0) begin
        rsp_if.ready <= 1'b0;
        g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 3);
        repeat (g) @(negedge clk_i);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(logic [15:0] x, logic [15:0] y, logic [15:0] z, bit gaps);
    int unsigned g;
    if (gaps) begin
      g = gap_len();
      if (g != 0) begin
        req_if.valid <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
    end
    req_if.data <= '{accel_x: x, accel_y: y, accel_z: z};
    req_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (tilt_sb.tilt_q.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_PROCESS_NOISE) tilt_sb.q_noise = val[15:0];
    else tilt_sb.r_noise = val;
  endtask

  task automatic random_phase(int n);
    logic [15:0] x, y, z;
    int unsigned m;
    for (int i = 0; i < n; i++) begin
      m = $urandom_range(0, 9);
      x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
      if (m < 3) begin
        // near-static sensor, small noise around a tilt
        x = 16'(int'($urandom_range(0, 800)) - 400 + 2000);
        y = 16'(int'($urandom_range(0, 800)) - 400 - 3000);
        z = 16'(int'($urandom_range(0, 800)) - 400 + 16384);
      end else if (m == 3) begin
        x = 16'(int'($urandom_range(0, 6)) - 3);
        y = 16'(int'($urandom_range(0, 6)) - 3);
        z = 16'(int'($urandom_range(0, 6)) - 3);
      end
      send_request(x, y, z, (i % 100) < 80);
    end
  endtask

  initial begin
    tilt_sb = new();
    tilt_sb.reset_state();
    req_if.valid = 1'b0;
    req_if.data = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: zero vector, extremes, negative cosine side, axes
    send_request(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_request(16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
    send_request(16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_request(16'h0000, 16'h0000, 16'h8000, 1'b0);
    send_request(16'h0000, 16'h0000, 16'h7fff, 1'b0);
    send_request(16'h7fff, 16'h0000, 16'h0000, 1'b0);
    send_request(16'h8000, 16'h0000, 16'h0000, 1'b0);
    send_request(16'h0000, 16'h7fff, 16'h0000, 1'b0);
    send_request(16'h0000, 16'h8000, 16'h0000, 1'b0);
    send_request(16'h0001, 16'hffff, 16'h8000, 1'b0);
    send_request(16'hffff, 16'h0001, 16'hffff, 1'b0);
    send_request(16'h5555, 16'haaaa, 16'h4000, 1'b0);
    send_request(16'haaaa, 16'h5555, 16'hc000, 1'b0);
    drain();

    // covariance saturation, zero Q
    write_reg(REG_PROCESS_NOISE, 24'hffff);
    write_reg(REG_MEASUREMENT_NOISE, 24'hffffff);
    random_phase(120);
    drain();
    write_reg(REG_PROCESS_NOISE, 24'h0);
    write_reg(REG_MEASUREMENT_NOISE, 24'h1);
    random_phase(120);
    drain();
    write_reg(REG_PROCESS_NOISE, 24'd655);
    write_reg(REG_MEASUREMENT_NOISE, 24'd65536);
    random_phase(150);
    drain();
    for (int p = 0; p < 3; p++) begin
      write_reg(REG_PROCESS_NOISE, CfgDataW'($urandom_range(0, 65535)));
      write_reg(REG_MEASUREMENT_NOISE, CfgDataW'($urandom_range(1, 24'hffffff)));
      random_phase(100);
      drain();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    if (tilt_sb.errors == 0 && tilt_sb.tilt_q.size() == 0)
      $display("PASS accel_tilt_kalman_smoother_core");
    else
      $display("FAIL accel_tilt_kalman_smoother_core");
    $finish;
  end

  initial begin
    wait (idle_cycles >= 5000);
    $display("FAIL accel_tilt_kalman_smoother_core");
    $finish;
  end

endmodule
